// ===== src/wls_pkg.sv =====
// wls_pkg: shared widths, group codes and controller/datapath link structs
// for the windowed latency statistics block; no dependencies
package wls_pkg;

  localparam int unsigned LAT_W      = 31;
  localparam int unsigned TS_W       = 63;
  localparam int unsigned CFG_W      = 17;
  localparam int unsigned CNT_OUT_W  = 32;
  localparam int unsigned MEAN_W     = 39;
  localparam int unsigned WSUM_W     = 47;
  localparam int unsigned ROUND_W    = 32;
  localparam int unsigned GRP_W      = 2;
  localparam int unsigned TOTAL_W    = 64;
  localparam int unsigned GCNT_W     = 32;
  localparam int unsigned DIVD_W     = 64;
  localparam int unsigned DIVS_W     = 32;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 312;
  localparam int unsigned MIN_WINDOW = 8;

  // one quotient bit per step
  localparam int unsigned DIV_STEPS = MEAN_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_W-1:0]  WINDOW_RESET = 17'd1024;
  localparam logic [LAT_W-1:0]  LAT_MAX      = '1;
  localparam logic [WSUM_W-1:0] WSUM_MAX     = '1;

  typedef enum logic [GRP_W-1:0] {
    GRP_FULL   = 2'd0,
    GRP_HALF   = 2'd1,
    GRP_EIGHTH = 2'd2,
    GRP_GLOBAL = 2'd3
  } wls_grp_e;

  typedef struct packed {
    logic     take;
    logic     check;
    logic     div_start;
    logic     load_out;
    logic     finish;
    wls_grp_e grp;
  } wls_cmd_t;

  typedef struct packed {
    logic first_seen;
    logic full_due;
    logic div_done;
    logic out_free;
  } wls_sts_t;

endpackage

// ===== src/windowed_latency_statistics_top.sv =====
// windowed_latency_statistics_top: a sample with no report is taken in the idle state;
// the block is ready again after the window check, or in the next cycle for the opening
// sample; a report costs one serial divide per record (39 quotient bits at one bit per
// cycle), and no new sample is taken until the global record is loaded. rst_ni is
// asynchronous, active low: clears all statistics, round and start time, window size
// back to 1024; no clearing pass
module windowed_latency_statistics_top #(
  parameter int unsigned MAX_WINDOW = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wls_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // latency, timestamp, zero pad
  input  logic [wls_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // round_index, sample_count, min_latency, max_latency, spread, mean_latency,
  // window_sum, elapsed_time, zero pad
  output logic [wls_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // group
  output logic [wls_pkg::GRP_W-1:0]      m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import wls_pkg::*;

  wls_cmd_t             cmd;
  wls_sts_t             sts;
  logic [ROUND_W-1:0]   round_index;
  logic [CNT_OUT_W-1:0] sample_count;
  logic [LAT_W-1:0]     min_latency;
  logic [LAT_W-1:0]     max_latency;
  logic [LAT_W-1:0]     spread;
  logic [MEAN_W-1:0]    mean_latency;
  logic [WSUM_W-1:0]    window_sum;
  logic [TS_W-1:0]      elapsed_time;

  wls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wls_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .latency_i      (s_axis_tdata_i[LAT_W-1:0]),
    .timestamp_i    (s_axis_tdata_i[LAT_W+TS_W-1:LAT_W]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .round_index_o  (round_index),
    .group_o        (m_axis_tuser_o),
    .sample_count_o (sample_count),
    .min_latency_o  (min_latency),
    .max_latency_o  (max_latency),
    .spread_o       (spread),
    .mean_latency_o (mean_latency),
    .window_sum_o   (window_sum),
    .elapsed_time_o (elapsed_time),
    .last_o         (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'b0, elapsed_time, window_sum, mean_latency, spread,
                           max_latency, min_latency, sample_count, round_index};

endmodule

// ===== src/wls_div.sv =====
// wls_div: iterative restoring divider giving floor(dividend * 256 / divisor),
// saturated to the mean width, one quotient bit per cycle; uses wls_pkg
module wls_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wls_pkg::DIVD_W-1:0]  dividend_i,
  input  logic [wls_pkg::DIVS_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [wls_pkg::MEAN_W-1:0]  quotient_o
);
  import wls_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIVS_W-1:0]    rem_q;
  logic [DIVS_W-1:0]    dvs_q;
  logic [MEAN_W-1:0]    sh_q;
  logic [MEAN_W-1:0]    quo_q;

  logic [DIVS_W:0]      trial;
  logic [DIVS_W:0]      diff;
  logic                 ge;
  logic [DIVS_W-1:0]    rem_d;
  logic [DIVS_W:0]      head;
  logic                 sat;
  logic                 zero;

  always_comb begin
    trial = {rem_q, sh_q[MEAN_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
    rem_d = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    head  = dividend_i[DIVD_W-1:MEAN_W-8];
    zero  = divisor_i == '0;
    sat   = head >= {1'b0, divisor_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !zero && !sat;
        done_q <= zero || sat;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= head[DIVS_W-1:0];
      sh_q  <= {dividend_i[MEAN_W-9:0], 8'h00};
      quo_q <= (sat && !zero) ? '1 : '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[MEAN_W-2:0], 1'b0};
      quo_q <= {quo_q[MEAN_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/wls_datapath.sv =====
// wls_datapath: window, snapshot and global accumulators, size register,
// mean divider and output record register; uses wls_pkg and wls_div
module wls_datapath #(
  parameter int unsigned MAX_WINDOW = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wls_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [wls_pkg::LAT_W-1:0]     latency_i,
  input  logic [wls_pkg::TS_W-1:0]      timestamp_i,
  input  wls_pkg::wls_cmd_t             cmd_i,
  output wls_pkg::wls_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wls_pkg::ROUND_W-1:0]   round_index_o,
  output logic [wls_pkg::GRP_W-1:0]     group_o,
  output logic [wls_pkg::CNT_OUT_W-1:0] sample_count_o,
  output logic [wls_pkg::LAT_W-1:0]     min_latency_o,
  output logic [wls_pkg::LAT_W-1:0]     max_latency_o,
  output logic [wls_pkg::LAT_W-1:0]     spread_o,
  output logic [wls_pkg::MEAN_W-1:0]    mean_latency_o,
  output logic [wls_pkg::WSUM_W-1:0]    window_sum_o,
  output logic [wls_pkg::TS_W-1:0]      elapsed_time_o,
  output logic                          last_o
);
  import wls_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SW = LAT_W + CW;
  localparam logic [31:0] MAXW = 32'(MAX_WINDOW);
  localparam logic [31:0] MINW = 32'(MIN_WINDOW);

  logic [CFG_W-1:0]   window_size_q;
  logic               first_seen_q;
  logic [TS_W-1:0]    ts_q;
  logic [TS_W-1:0]    round_start_q;
  logic [ROUND_W-1:0] round_q;

  logic [SW-1:0]      win_sum_q  [3];
  logic [CW-1:0]      win_cnt_q  [3];
  logic [LAT_W-1:0]   win_min_q  [3];
  logic [LAT_W-1:0]   win_max_q  [3];
  logic [SW-1:0]      snap_sum_q [2];
  logic [CW-1:0]      snap_cnt_q [2];
  logic [LAT_W-1:0]   snap_min_q [2];
  logic [LAT_W-1:0]   snap_max_q [2];

  logic [TOTAL_W-1:0] glob_total_q;
  logic [GCNT_W-1:0]  glob_cnt_q;
  logic [LAT_W-1:0]   glob_low_q;
  logic [LAT_W-1:0]   glob_high_q;

  logic               out_valid_q;
  logic [ROUND_W-1:0] out_round_q;
  logic [GRP_W-1:0]   out_grp_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;
  logic [LAT_W-1:0]   out_min_q;
  logic [LAT_W-1:0]   out_max_q;
  logic [LAT_W-1:0]   out_spread_q;
  logic [MEAN_W-1:0]  out_mean_q;
  logic [WSUM_W-1:0]  out_wsum_q;
  logic [TS_W-1:0]    out_elapsed_q;
  logic               out_last_q;

  logic [31:0]        ws_ext;
  logic [31:0]        n_ext;
  logic [CW-1:0]      win_size [3];
  logic [2:0]         win_due;
  logic               accum;
  logic [TOTAL_W:0]   glob_add;
  logic [DIVD_W-1:0]  sel_sum;
  logic [DIVS_W-1:0]  sel_cnt;
  logic [LAT_W-1:0]   sel_min;
  logic [LAT_W-1:0]   sel_max;
  logic [63:0]        fsum_ext;
  logic [WSUM_W-1:0]  wsum_sat;
  logic               div_done;
  logic [MEAN_W-1:0]  div_quo;
  logic               out_free;

  // size clamp and window thresholds
  always_comb begin
    ws_ext = 32'(window_size_q);
    if (ws_ext < MINW) begin
      n_ext = MINW;
    end else if (ws_ext > MAXW) begin
      n_ext = MAXW;
    end else begin
      n_ext = ws_ext;
    end
    win_size[0] = n_ext[CW-1:0];
    win_size[1] = n_ext[CW-1:0] >> 1;
    win_size[2] = n_ext[CW-1:0] >> 3;
    for (int w = 0; w < 3; w++) begin
      win_due[w] = win_cnt_q[w] >= win_size[w];
    end
  end

  assign accum    = cmd_i.take && first_seen_q;
  assign glob_add = {1'b0, glob_total_q} + (TOTAL_W + 1)'(latency_i);

  always_comb begin
    case (cmd_i.grp)
      GRP_FULL: begin
        sel_sum = DIVD_W'(win_sum_q[0]);
        sel_cnt = DIVS_W'(win_cnt_q[0]);
        sel_min = win_min_q[0];
        sel_max = win_max_q[0];
      end
      GRP_HALF: begin
        sel_sum = DIVD_W'(snap_sum_q[0]);
        sel_cnt = DIVS_W'(snap_cnt_q[0]);
        sel_min = snap_min_q[0];
        sel_max = snap_max_q[0];
      end
      GRP_EIGHTH: begin
        sel_sum = DIVD_W'(snap_sum_q[1]);
        sel_cnt = DIVS_W'(snap_cnt_q[1]);
        sel_min = snap_min_q[1];
        sel_max = snap_max_q[1];
      end
      default: begin
        sel_sum = glob_total_q;
        sel_cnt = glob_cnt_q;
        sel_min = glob_low_q;
        sel_max = glob_high_q;
      end
    endcase
    fsum_ext = 64'(win_sum_q[0]);
    wsum_sat = (fsum_ext > 64'(WSUM_MAX)) ? WSUM_MAX : fsum_ext[WSUM_W-1:0];
  end

  wls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sel_sum),
    .divisor_i  (sel_cnt),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      window_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      ts_q <= timestamp_i;
    end
  end

  // round bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_seen_q  <= 1'b0;
      round_start_q <= '0;
      round_q       <= '0;
    end else begin
      if (cmd_i.take && !first_seen_q) begin
        first_seen_q  <= 1'b1;
        round_start_q <= timestamp_i;
      end
      if (cmd_i.finish) begin
        round_start_q <= ts_q;
        round_q       <= round_q + ROUND_W'(1);
      end
    end
  end

  // windows and snapshots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < 3; w++) begin
        win_sum_q[w] <= '0;
        win_cnt_q[w] <= '0;
        win_min_q[w] <= LAT_MAX;
        win_max_q[w] <= '0;
      end
      for (int s = 0; s < 2; s++) begin
        snap_sum_q[s] <= '0;
        snap_cnt_q[s] <= '0;
        snap_min_q[s] <= '0;
        snap_max_q[s] <= '0;
      end
    end else begin
      if (accum) begin
        for (int w = 0; w < 3; w++) begin
          win_sum_q[w] <= win_sum_q[w] + SW'(latency_i);
          win_cnt_q[w] <= win_cnt_q[w] + CW'(1);
          if (latency_i < win_min_q[w]) begin
            win_min_q[w] <= latency_i;
          end
          if (latency_i > win_max_q[w]) begin
            win_max_q[w] <= latency_i;
          end
        end
      end
      if (cmd_i.check) begin
        for (int w = 1; w < 3; w++) begin
          if (win_due[w]) begin
            snap_sum_q[w-1] <= win_sum_q[w];
            snap_cnt_q[w-1] <= win_cnt_q[w];
            snap_min_q[w-1] <= win_min_q[w];
            snap_max_q[w-1] <= win_max_q[w];
            win_sum_q[w]    <= '0;
            win_cnt_q[w]    <= '0;
            win_min_q[w]    <= LAT_MAX;
            win_max_q[w]    <= '0;
          end
        end
      end
      if (cmd_i.finish) begin
        for (int w = 0; w < 3; w++) begin
          win_sum_q[w] <= '0;
          win_cnt_q[w] <= '0;
          win_min_q[w] <= LAT_MAX;
          win_max_q[w] <= '0;
        end
        for (int s = 0; s < 2; s++) begin
          snap_sum_q[s] <= '0;
          snap_cnt_q[s] <= '0;
          snap_min_q[s] <= '0;
          snap_max_q[s] <= '0;
        end
      end
    end
  end

  // all-time totals, saturating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glob_total_q <= '0;
      glob_cnt_q   <= '0;
      glob_low_q   <= LAT_MAX;
      glob_high_q  <= '0;
    end else if (accum) begin
      glob_total_q <= glob_add[TOTAL_W] ? '1 : glob_add[TOTAL_W-1:0];
      if (glob_cnt_q != '1) begin
        glob_cnt_q <= glob_cnt_q + GCNT_W'(1);
      end
      if (latency_i < glob_low_q) begin
        glob_low_q <= latency_i;
      end
      if (latency_i > glob_high_q) begin
        glob_high_q <= latency_i;
      end
    end
  end

  // output record register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_round_q   <= round_q;
      out_grp_q     <= cmd_i.grp;
      out_cnt_q     <= sel_cnt;
      out_min_q     <= sel_min;
      out_max_q     <= sel_max;
      out_spread_q  <= (sel_max >= sel_min) ? (sel_max - sel_min) : '0;
      out_mean_q    <= div_quo;
      out_wsum_q    <= wsum_sat;
      out_elapsed_q <= ts_q - round_start_q;
      out_last_q    <= cmd_i.grp == GRP_GLOBAL;
    end
  end

  assign sts_o.first_seen = first_seen_q;
  assign sts_o.full_due   = win_due[0];
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = out_free;

  assign out_valid_o    = out_valid_q;
  assign round_index_o  = out_round_q;
  assign group_o        = out_grp_q;
  assign sample_count_o = out_cnt_q;
  assign min_latency_o  = out_min_q;
  assign max_latency_o  = out_max_q;
  assign spread_o       = out_spread_q;
  assign mean_latency_o = out_mean_q;
  assign window_sum_o   = out_wsum_q;
  assign elapsed_time_o = out_elapsed_q;
  assign last_o         = out_last_q;

endmodule

// ===== src/wls_ctrl.sv =====
// wls_ctrl: sequencer for sample intake, window checks and the four-record
// report, one mean divide per record; uses wls_pkg
module wls_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wls_pkg::wls_sts_t sts_i,
  output wls_pkg::wls_cmd_t cmd_o
);
  import wls_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e   state_q, state_d;
  wls_grp_e grp_q, grp_d;
  wls_grp_e grp_next;

  always_comb begin
    case (grp_q)
      GRP_FULL:   grp_next = GRP_HALF;
      GRP_HALF:   grp_next = GRP_EIGHTH;
      GRP_EIGHTH: grp_next = GRP_GLOBAL;
      default:    grp_next = GRP_FULL;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    grp_d      = grp_q;
    cmd_o      = '0;
    cmd_o.grp  = grp_q;
    in_ready_o = state_q == ST_IDLE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.first_seen) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.full_due) begin
          grp_d   = GRP_FULL;
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (grp_q == GRP_GLOBAL) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            grp_d   = grp_next;
            state_d = ST_DIV;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      grp_q   <= GRP_FULL;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
    end
  end

endmodule

// ===== src/wls_checker.sv =====
// wls_checker: port-level checks on the report stream of the statistics block,
// bound to windowed_latency_statistics_top; uses wls_pkg
module wls_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [wls_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [wls_pkg::GRP_W-1:0]      m_axis_tuser_o,
  input logic                           m_axis_tlast_o
);
  import wls_pkg::*;

  logic [CNT_OUT_W-1:0] cnt;
  logic [LAT_W-1:0]     mn;
  logic [LAT_W-1:0]     mx;
  logic [LAT_W-1:0]     spr;
  logic [MEAN_W-1:0]    mean;

  assign cnt  = m_axis_tdata_o[63:32];
  assign mn   = m_axis_tdata_o[94:64];
  assign mx   = m_axis_tdata_o[125:95];
  assign spr  = m_axis_tdata_o[156:126];
  assign mean = m_axis_tdata_o[195:157];

  // stalled transfer keeps its record
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("report record changed while stalled");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == GRP_GLOBAL)))
    else $error("tlast does not mark the global record");

  a_spread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (mx >= mn) && (spr == mx - mn))
    else $error("spread inconsistent with min and max");

  // full window mean lies between its min and max
  a_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == GRP_FULL) |->
      (cnt != '0) && (mean >= {mn, 8'h00}) && (mean <= {mx, 8'hff}))
    else $error("full window mean out of range");

endmodule

bind windowed_latency_statistics_top wls_checker u_wls_checker (.*);

// ===== bench/windowed_latency_statistics_top_test.sv =====
`timescale 1ns / 1ps
// windowed_latency_statistics_top_test: directed and random latency sample streams,
// each report record checked against a behavioural model of the windowed statistics
// depends on wls_pkg and windowed_latency_statistics_top
module windowed_latency_statistics_top_test;
  import wls_pkg::*;

  localparam int unsigned WINDOW_CAP = 65536;
  localparam logic [31:0] LAT_TOP = 32'h7FFF_FFFF;

  typedef struct {
    logic [31:0] round_index;
    wls_grp_e    grp;
    logic [31:0] count;
    logic [30:0] min_lat;
    logic [30:0] max_lat;
    logic [30:0] spread;
    logic [38:0] mean;
    logic [46:0] wsum;
    logic [62:0] elapsed;
    logic        is_last;
  } lat_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [GRP_W-1:0]      m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  windowed_latency_statistics_top #(
    .MAX_WINDOW(WINDOW_CAP)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // statistics model state
  logic [CFG_W-1:0] window_reg = WINDOW_RESET;
  logic             started = 1'b0;
  logic [62:0]      round_start = '0;
  logic [31:0]      rounds_done = '0;
  logic [63:0]      win_sum [3] = '{default: '0};
  logic [31:0]      win_cnt [3] = '{default: '0};
  logic [31:0]      win_min [3] = '{default: LAT_TOP};
  logic [31:0]      win_max [3] = '{default: '1};
  logic [31:0]      snap_cnt [2] = '{default: '0};
  logic [31:0]      snap_min [2] = '{default: '0};
  logic [31:0]      snap_max [2] = '{default: '0};
  logic [38:0]      snap_mean [2] = '{default: '0};
  logic [63:0]      total_sum = '0;
  logic [31:0]      total_cnt = '0;
  logic [31:0]      total_min = LAT_TOP;
  logic [31:0]      total_max = '1;

  lat_report_t      expected_reports [$];
  int unsigned      mismatches = 0;
  int unsigned      samples_sent = 0;
  int unsigned      gap_max = 0;
  int unsigned      burst_left = 0;
  logic [62:0]      event_clock = '0;
  logic [15:0]      ready_pattern = '1;
  logic [3:0]       pattern_pos = '0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("windowed_latency_statistics_top verification failed");
    $finish;
  end

  // sink stall pattern, re-picked each time pattern_pos wraps, sometimes fully open
  always @(posedge clk_i) begin
    if (pattern_pos == 4'd15) begin
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end
    pattern_pos <= pattern_pos + 4'd1;
    m_axis_tready_i <= ready_pattern[pattern_pos];
  end

  function automatic logic [38:0] mean_fixed(input logic [63:0] sum, input logic [63:0] cnt);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] m;
    if (cnt == 0) return '0;
    q = sum / cnt;
    r = sum % cnt;
    if (q > 64'h7FFF_FFFF) return '1;
    m = (q << 8) + ((r << 8) / cnt);
    return (m > 64'h7F_FFFF_FFFF) ? '1 : m[38:0];
  endfunction

  function automatic lat_report_t make_record(input wls_grp_e grp, input logic [31:0] cnt,
                                              input logic [31:0] mn, input logic [31:0] mx,
                                              input logic [38:0] mean, input logic [46:0] wsum,
                                              input logic [62:0] el);
    lat_report_t rec;
    logic [31:0] diff;
    diff = mx - mn;
    rec.round_index = rounds_done;
    rec.grp = grp;
    rec.count = cnt;
    rec.min_lat = mn[30:0];
    rec.max_lat = mx[30:0];
    rec.spread = (mx >= mn) ? diff[30:0] : '0;
    rec.mean = mean;
    rec.wsum = wsum;
    rec.elapsed = el;
    rec.is_last = (grp == GRP_GLOBAL);
    return rec;
  endfunction

  task automatic clear_window(input int w);
    win_sum[w] = '0;
    win_cnt[w] = '0;
    win_min[w] = LAT_TOP;
    win_max[w] = '1;
  endtask

  task automatic predict_sample(input logic [30:0] lat, input logic [62:0] ts);
    logic [31:0] n;
    logic [31:0] sizes [3];
    logic [46:0] wsum;
    logic [62:0] el;
    if (!started) begin
      started = 1'b1;
      round_start = ts;
      return;
    end
    n = 32'(window_reg);
    if (n < MIN_WINDOW) n = MIN_WINDOW;
    if (n > WINDOW_CAP) n = WINDOW_CAP;
    sizes[0] = n;
    sizes[1] = n / 2;
    sizes[2] = n / 8;
    for (int w = 0; w < 3; w++) begin
      win_sum[w] = win_sum[w] + lat;
      win_cnt[w] = win_cnt[w] + 1;
      if (lat < win_min[w]) win_min[w] = 32'(lat);
      if (win_max[w] == '1 || lat > win_max[w]) win_max[w] = 32'(lat);
    end
    total_sum = (total_sum > 64'hFFFF_FFFF_FFFF_FFFF - lat) ? '1 : total_sum + lat;
    if (total_cnt != '1) total_cnt = total_cnt + 1;
    if (lat < total_min) total_min = 32'(lat);
    if (total_max == '1 || lat > total_max) total_max = 32'(lat);
    for (int w = 1; w < 3; w++) begin
      if (win_cnt[w] >= sizes[w]) begin
        snap_cnt[w-1] = win_cnt[w];
        snap_mean[w-1] = mean_fixed(win_sum[w], 64'(win_cnt[w]));
        snap_min[w-1] = win_min[w];
        snap_max[w-1] = win_max[w];
        clear_window(w);
      end
    end
    if (win_cnt[0] < sizes[0]) return;
    wsum = (win_sum[0] > 64'h7FFF_FFFF_FFFF) ? '1 : win_sum[0][46:0];
    el = ts - round_start;
    expected_reports.push_back(make_record(GRP_FULL, win_cnt[0], win_min[0], win_max[0],
                               mean_fixed(win_sum[0], 64'(win_cnt[0])), wsum, el));
    expected_reports.push_back(make_record(GRP_HALF, snap_cnt[0], snap_min[0], snap_max[0],
                               snap_mean[0], wsum, el));
    expected_reports.push_back(make_record(GRP_EIGHTH, snap_cnt[1], snap_min[1], snap_max[1],
                               snap_mean[1], wsum, el));
    expected_reports.push_back(make_record(GRP_GLOBAL, total_cnt, total_min, total_max,
                               mean_fixed(total_sum, 64'(total_cnt)), wsum, el));
    for (int w = 0; w < 3; w++) begin
      clear_window(w);
    end
    snap_cnt = '{default: '0};
    snap_min = '{default: '0};
    snap_max = '{default: '0};
    snap_mean = '{default: '0};
    rounds_done = rounds_done + 1;
    round_start = ts;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  always @(posedge clk_i) begin
    lat_report_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("record with none pending", 64'(m_axis_tuser_o), '0);
      end else begin
        want = expected_reports.pop_front();
        check_field("round_index", 64'(m_axis_tdata_o[31:0]), 64'(want.round_index));
        check_field("sample_count", 64'(m_axis_tdata_o[63:32]), 64'(want.count));
        check_field("min_latency", 64'(m_axis_tdata_o[94:64]), 64'(want.min_lat));
        check_field("max_latency", 64'(m_axis_tdata_o[125:95]), 64'(want.max_lat));
        check_field("spread", 64'(m_axis_tdata_o[156:126]), 64'(want.spread));
        check_field("mean_latency", 64'(m_axis_tdata_o[195:157]), 64'(want.mean));
        check_field("window_sum", 64'(m_axis_tdata_o[242:196]), 64'(want.wsum));
        check_field("elapsed_time", 64'(m_axis_tdata_o[305:243]), 64'(want.elapsed));
        check_field("group", 64'(m_axis_tuser_o), 64'(want.grp));
        check_field("tlast", 64'(m_axis_tlast_o), 64'(want.is_last));
      end
    end
  end

  task automatic send_sample(input logic [30:0] lat, input logic [62:0] ts);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {2'b00, ts, lat};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_sample(lat, ts);
    samples_sent++;
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = $urandom_range(1, gap_max);
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_random_sample();
    logic [30:0] lat;
    case ($urandom_range(0, 4))
      0: lat = 31'($urandom);
      1: lat = 31'($urandom_range(0, 255));
      2: lat = 31'(LAT_TOP) - 31'($urandom_range(0, 255));
      default: lat = 31'($urandom_range(0, 1_000_000));
    endcase
    if ($urandom_range(0, 9) == 0) begin
      event_clock = 63'({$urandom, $urandom});
    end else begin
      event_clock = event_clock + 63'($urandom_range(1, 100_000));
    end
    send_sample(lat, event_clock);
  endtask

  // a sample with no report still keeps the block busy through its window check
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [CFG_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_reg = value;
  endtask

  task automatic send_steps(input int unsigned count, input logic [30:0] lat);
    repeat (count) begin
      event_clock = event_clock + 63'd1000;
      send_sample(lat, event_clock);
    end
  endtask

  // first sample after reset only opens the round
  task automatic test_round_start();
    set_window('0);
    send_sample(31'd5, 63'd1000);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    send_sample('0, 63'd2000);
    send_sample(31'(LAT_TOP), 63'h7FFF_FFFF_FFFF_FFFF);
    send_sample(31'(LAT_TOP), 63'd0);
    send_sample('0, 63'd5000);
    send_sample(31'd1, 63'h5555_5555_5555_5555);
    send_sample(31'(LAT_TOP) - 31'd1, 63'h2AAA_AAAA_AAAA_AAAA);
    send_sample(31'h2AAA_AAAA, 63'd7000);
    // timestamp behind the round start, elapsed time wraps
    send_sample(31'h5555_5555, 63'd500);
    wait_idle();
    event_clock = 63'd500;
  endtask

  task automatic test_window_resize();
    gap_max = 4;
    set_window('1);
    send_steps(8, 31'd300);
    wait_idle();
    // shrink to the running count, the report comes with the next sample
    set_window(17'd8);
    send_steps(1, 31'd7);
    wait_idle();
    set_window(17'd24);
    send_steps(3, 31'd900);
    wait_idle();
    set_window(17'(WINDOW_CAP));
    send_steps(1, 31'd11);
    wait_idle();
    set_window(17'd9);
    send_steps(5, 31'd40);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned phase_len;
    while (samples_sent < 310) begin
      case ($urandom_range(0, 9))
        0: set_window(17'($urandom_range(0, MIN_WINDOW - 1)));
        1: set_window(17'($urandom_range(WINDOW_CAP, 17'h1FFFF)));
        default: set_window(17'($urandom_range(MIN_WINDOW, 32)));
      endcase
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      phase_len = $urandom_range(3, 40);
      repeat (phase_len) send_random_sample();
      wait_idle();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_round_start();
    test_field_extremes();
    test_window_resize();
    test_random_traffic();
    wait_idle();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("windowed_latency_statistics_top verification clean");
    end else begin
      $display("windowed_latency_statistics_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wls_pkg.sv
src/wls_div.sv
src/wls_datapath.sv
src/wls_ctrl.sv
src/windowed_latency_statistics_top.sv
src/wls_checker.sv
bench/windowed_latency_statistics_top_test.sv
